// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is held low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/cmot_pkg.sv =====
package cmot_pkg;

  // Function codes of an input transaction
  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_REFRESH = 2'd1,
    FUNC_LOAD    = 2'd2
  } func_e;

  // Count and field widths
  localparam int unsigned CNT_W     = 14;
  localparam int unsigned LOAD_W    = 13;
  localparam int unsigned MAG_W     = 14;
  localparam int unsigned QUO60_W   = 9;
  localparam int unsigned MINS_W    = 8;
  localparam int unsigned SECS_W    = 6;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned SEC_TENS_W = 3;

  // Count at or below which overtime stops the timer (magnitude past 599)
  localparam logic signed [CNT_W-1:0] COUNT_STOP = -14'sd600;

  // Constant division by 60: multiply, shift, then one correction step
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned DIV60_MUL    = 1092;
  localparam int unsigned DIV60_MUL_W  = 11;
  localparam int unsigned DIV60_SHIFT  = 16;

  // Constant division by 10, exact for values below 1029
  localparam int unsigned DIGIT_BASE   = 10;
  localparam int unsigned DIV10_MUL    = 205;
  localparam int unsigned DIV10_MUL_W  = 8;
  localparam int unsigned DIV10_SHIFT  = 11;

  // Per-result flags carried down the pipeline
  typedef struct packed {
    logic minus_shown;
    logic colon_on;
    logic counted;
    logic overtime;
    logic running;
  } flags_t;

endpackage

// ===== rtl/cmot_exec.sv =====
module cmot_exec (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [1:0]                        func_i,
  input  logic [cmot_pkg::LOAD_W-1:0]       load_seconds_i,
  input  logic                              load_enable_i,
  input  logic                              channel_busy_i,
  output cmot_pkg::flags_t                  flags_o,
  output logic [cmot_pkg::MAG_W-1:0]        mag_o
);

  logic [cmot_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_dec;
  logic                       run_q, run_d;
  logic                       refr_q, refr_d;
  logic                       colon_q, colon_d;
  cmot_pkg::flags_t           flags_d, flags_q;
  logic [cmot_pkg::MAG_W-1:0] mag_d, mag_q;
  logic                       fire;

  assign fire    = en_i & valid_i;
  assign cnt_dec = cnt_q - cmot_pkg::CNT_W'(1);

  // Apply one transaction to the timer state
  always_comb begin
    cnt_d   = cnt_q;
    run_d   = run_q;
    refr_d  = refr_q;
    colon_d = colon_q;
    flags_d = '0;
    mag_d   = '0;
    case (func_i)
      cmot_pkg::FUNC_TICK: begin
        // count only once per refresh
        if (refr_q) begin
          if (run_q && !channel_busy_i) begin
            cnt_d           = cnt_dec;
            flags_d.counted = 1'b1;
            if (cnt_dec[cmot_pkg::CNT_W-1]) begin
              flags_d.overtime = 1'b1;
              if ($signed(cnt_dec) <= cmot_pkg::COUNT_STOP) begin
                run_d = 1'b0;
              end
            end
          end
          refr_d = 1'b0;
        end
      end
      cmot_pkg::FUNC_REFRESH: begin
        flags_d.minus_shown = cnt_q[cmot_pkg::CNT_W-1];
        mag_d = cnt_q[cmot_pkg::CNT_W-1] ? (~cnt_q + cmot_pkg::CNT_W'(1)) : cnt_q;
        // first refresh after a tick re-arms the colon, so it shows on
        colon_d          = refr_q ? ~colon_q : 1'b1;
        refr_d           = 1'b1;
        flags_d.colon_on = colon_d;
      end
      cmot_pkg::FUNC_LOAD: begin
        cnt_d = {1'b0, load_seconds_i};
        run_d = load_enable_i;
      end
      default: begin
      end
    endcase
    flags_d.running = run_d;
  end

  // Hold timer state between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      run_q   <= 1'b0;
      refr_q  <= 1'b0;
      colon_q <= 1'b0;
    end else if (fire) begin
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      refr_q  <= refr_d;
      colon_q <= colon_d;
    end
  end

  // Register the stage result
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= flags_d;
      mag_q   <= mag_d;
    end
  end

  assign flags_o = flags_q;
  assign mag_o   = mag_q;

endmodule

// ===== rtl/cmot_div60.sv =====
module cmot_div60 (
  input  logic                              clk_i,
  input  logic                              en_a_i,
  input  logic                              en_b_i,
  input  cmot_pkg::flags_t                  flags_i,
  input  logic [cmot_pkg::MAG_W-1:0]        mag_i,
  output cmot_pkg::flags_t                  flags_o,
  output logic [cmot_pkg::MINS_W-1:0]       mins_o,
  output logic [cmot_pkg::SECS_W-1:0]       secs_o
);

  localparam int unsigned PROD_W = cmot_pkg::MAG_W + cmot_pkg::DIV60_MUL_W;
  localparam int unsigned REM_W  = cmot_pkg::MAG_W + 1;

  logic [PROD_W-1:0]                prod;
  logic [cmot_pkg::QUO60_W-1:0]     quo_d, quo_q;
  logic [cmot_pkg::MAG_W-1:0]       mag_q;
  cmot_pkg::flags_t                 flags_a_q, flags_b_q;
  logic [REM_W-1:0]                 back, rem;
  logic [cmot_pkg::MINS_W-1:0]      mins_d, mins_q;
  logic [cmot_pkg::SECS_W-1:0]      secs_d, secs_q;

  // Estimate the quotient from below, off by at most one
  assign prod  = PROD_W'(mag_i) * PROD_W'(cmot_pkg::DIV60_MUL);
  assign quo_d = prod[cmot_pkg::DIV60_SHIFT +: cmot_pkg::QUO60_W];

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      quo_q     <= quo_d;
      mag_q     <= mag_i;
      flags_a_q <= flags_i;
    end
  end

  // Form the remainder and correct the estimate once
  assign back = REM_W'(quo_q) * REM_W'(cmot_pkg::SEC_PER_MIN);
  assign rem  = REM_W'(mag_q) - back;

  always_comb begin
    if (rem >= REM_W'(cmot_pkg::SEC_PER_MIN)) begin
      mins_d = cmot_pkg::MINS_W'(quo_q + cmot_pkg::QUO60_W'(1));
      secs_d = cmot_pkg::SECS_W'(rem - REM_W'(cmot_pkg::SEC_PER_MIN));
    end else begin
      mins_d = cmot_pkg::MINS_W'(quo_q);
      secs_d = cmot_pkg::SECS_W'(rem);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      mins_q    <= mins_d;
      secs_q    <= secs_d;
      flags_b_q <= flags_a_q;
    end
  end

  assign flags_o = flags_b_q;
  assign mins_o  = mins_q;
  assign secs_o  = secs_q;

endmodule

// ===== rtl/cmot_digits.sv =====
module cmot_digits (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  cmot_pkg::flags_t                  flags_i,
  input  logic [cmot_pkg::MINS_W-1:0]       mins_i,
  input  logic [cmot_pkg::SECS_W-1:0]       secs_i,
  output cmot_pkg::flags_t                  flags_o,
  output logic [cmot_pkg::DIGIT_W-1:0]      min_tens_o,
  output logic [cmot_pkg::DIGIT_W-1:0]      min_units_o,
  output logic [cmot_pkg::SEC_TENS_W-1:0]   sec_tens_o,
  output logic [cmot_pkg::DIGIT_W-1:0]      sec_units_o
);

  localparam int unsigned MPROD_W = cmot_pkg::MINS_W + cmot_pkg::DIV10_MUL_W;
  localparam int unsigned SPROD_W = cmot_pkg::SECS_W + cmot_pkg::DIV10_MUL_W;
  localparam int unsigned MQ_W    = MPROD_W - cmot_pkg::DIV10_SHIFT;
  localparam int unsigned SQ_W    = SPROD_W - cmot_pkg::DIV10_SHIFT;

  logic [MPROD_W-1:0]                 mprod;
  logic [SPROD_W-1:0]                 sprod;
  logic [MQ_W-1:0]                    mq;
  logic [SQ_W-1:0]                    sq;
  logic [cmot_pkg::MINS_W-1:0]        mu;
  logic [cmot_pkg::SECS_W-1:0]        su;
  cmot_pkg::flags_t                   flags_q;
  logic [cmot_pkg::DIGIT_W-1:0]       mt_q, mu_q, su_q;
  logic [cmot_pkg::SEC_TENS_W-1:0]    st_q;

  // Split minutes and seconds into tens and units
  assign mprod = MPROD_W'(mins_i) * MPROD_W'(cmot_pkg::DIV10_MUL);
  assign sprod = SPROD_W'(secs_i) * SPROD_W'(cmot_pkg::DIV10_MUL);
  assign mq    = mprod[MPROD_W-1:cmot_pkg::DIV10_SHIFT];
  assign sq    = sprod[SPROD_W-1:cmot_pkg::DIV10_SHIFT];
  assign mu    = mins_i - cmot_pkg::MINS_W'(mq) * cmot_pkg::MINS_W'(cmot_pkg::DIGIT_BASE);
  assign su    = secs_i - cmot_pkg::SECS_W'(sq) * cmot_pkg::SECS_W'(cmot_pkg::DIGIT_BASE);

  // Register the result; minus sign takes the place of minute tens
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_q <= flags_i;
      mt_q    <= flags_i.minus_shown ? '0 : cmot_pkg::DIGIT_W'(mq);
      mu_q    <= cmot_pkg::DIGIT_W'(mu);
      st_q    <= cmot_pkg::SEC_TENS_W'(sq);
      su_q    <= cmot_pkg::DIGIT_W'(su);
    end
  end

  assign flags_o     = flags_q;
  assign min_tens_o  = mt_q;
  assign min_units_o = mu_q;
  assign sec_tens_o  = st_q;
  assign sec_units_o = su_q;

endmodule

// ===== rtl/countdown_mmss_overtime_timer.sv =====
// Seconds countdown timer with overtime and an mm:ss digit readout. Send a
// load transaction to set the count and run enable, a tick once per second
// and a refresh to read the digits; each transaction yields one result. One
// transaction is taken per clock cycle when no stage stalls, and its result
// passes in order through an input register, the state update stage (count,
// enable, colon phase, all read and written in that stage), two stages of
// the divide by 60 and the digit split stage that is also the output
// register. Every stage moves on when the one after it is empty or moving,
// so a stall on the output holds back the full stages before it.
module countdown_mmss_overtime_timer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        func_i,
  input  logic [cmot_pkg::LOAD_W-1:0]       load_seconds_i,
  input  logic                              load_enable_i,
  input  logic                              channel_busy_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cmot_pkg::DIGIT_W-1:0]      min_tens_o,
  output logic [cmot_pkg::DIGIT_W-1:0]      min_units_o,
  output logic [cmot_pkg::SEC_TENS_W-1:0]   sec_tens_o,
  output logic [cmot_pkg::DIGIT_W-1:0]      sec_units_o,
  output logic                              minus_shown_o,
  output logic                              colon_on_o,
  output logic                              counted_o,
  output logic                              overtime_o,
  output logic                              running_o
);

  logic                         v_in_q, v_ex_q, v_a_q, v_b_q, v_out_q;
  logic                         en_in, en_ex, en_a, en_b, en_out;
  logic [1:0]                   func_q;
  logic [cmot_pkg::LOAD_W-1:0]  load_seconds_q;
  logic                         load_enable_q;
  logic                         channel_busy_q;
  cmot_pkg::flags_t             flags_ex, flags_b, flags_out;
  logic [cmot_pkg::MAG_W-1:0]   mag_ex;
  logic [cmot_pkg::MINS_W-1:0]  mins_b;
  logic [cmot_pkg::SECS_W-1:0]  secs_b;

  // Advance a stage when the next one is empty or advancing
  assign en_out     = ~v_out_q | out_ready_i;
  assign en_b       = ~v_b_q | en_out;
  assign en_a       = ~v_a_q | en_b;
  assign en_ex      = ~v_ex_q | en_a;
  assign en_in      = ~v_in_q | en_ex;
  assign in_ready_o = en_in;

  // Track which stages hold a transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q  <= 1'b0;
      v_ex_q  <= 1'b0;
      v_a_q   <= 1'b0;
      v_b_q   <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      if (en_in)  v_in_q  <= in_valid_i;
      if (en_ex)  v_ex_q  <= v_in_q;
      if (en_a)   v_a_q   <= v_ex_q;
      if (en_b)   v_b_q   <= v_a_q;
      if (en_out) v_out_q <= v_b_q;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (en_in) begin
      func_q         <= func_i;
      load_seconds_q <= load_seconds_i;
      load_enable_q  <= load_enable_i;
      channel_busy_q <= channel_busy_i;
    end
  end

  cmot_exec u_exec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en_ex),
    .valid_i        (v_in_q),
    .func_i         (func_q),
    .load_seconds_i (load_seconds_q),
    .load_enable_i  (load_enable_q),
    .channel_busy_i (channel_busy_q),
    .flags_o        (flags_ex),
    .mag_o          (mag_ex)
  );

  cmot_div60 u_div60 (
    .clk_i   (clk_i),
    .en_a_i  (en_a),
    .en_b_i  (en_b),
    .flags_i (flags_ex),
    .mag_i   (mag_ex),
    .flags_o (flags_b),
    .mins_o  (mins_b),
    .secs_o  (secs_b)
  );

  cmot_digits u_digits (
    .clk_i       (clk_i),
    .en_i        (en_out),
    .flags_i     (flags_b),
    .mins_i      (mins_b),
    .secs_i      (secs_b),
    .flags_o     (flags_out),
    .min_tens_o  (min_tens_o),
    .min_units_o (min_units_o),
    .sec_tens_o  (sec_tens_o),
    .sec_units_o (sec_units_o)
  );

  assign out_valid_o   = v_out_q;
  assign minus_shown_o = flags_out.minus_shown;
  assign colon_on_o    = flags_out.colon_on;
  assign counted_o     = flags_out.counted;
  assign overtime_o    = flags_out.overtime;
  assign running_o     = flags_out.running;

endmodule

// ===== rtl/cmot_checker.sv =====
`include "assert_macros.svh"

module cmot_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [1:0]                        func_i,
  input logic [cmot_pkg::LOAD_W-1:0]       load_seconds_i,
  input logic                              load_enable_i,
  input logic                              channel_busy_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [cmot_pkg::DIGIT_W-1:0]      min_tens_o,
  input logic [cmot_pkg::DIGIT_W-1:0]      min_units_o,
  input logic [cmot_pkg::SEC_TENS_W-1:0]   sec_tens_o,
  input logic [cmot_pkg::DIGIT_W-1:0]      sec_units_o,
  input logic                              minus_shown_o,
  input logic                              colon_on_o,
  input logic                              counted_o,
  input logic                              overtime_o,
  input logic                              running_o
);

  logic                          in_stall;
  logic [cmot_pkg::LOAD_W+3:0]   in_bus;

  // Gather the waiting input transaction
  assign in_stall = in_valid_i && !in_ready_o;
  assign in_bus   = {func_i, load_seconds_i, load_enable_i, channel_busy_i};

  // A waiting input holds its valid and its fields
  `ASSERT_CLK(a_in_hold, clk_i, rst_ni, in_stall |=> in_valid_i && $stable(in_bus), "input not held")

  // A stalled result holds its valid and its fields
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable({min_tens_o, min_units_o, sec_tens_o, sec_units_o, minus_shown_o, colon_on_o, counted_o, overtime_o, running_o}), "stalled result changed")

  // Minus sign replaces minute tens
  `ASSERT_CLK(a_minus_blank, clk_i, rst_ni, out_valid_o && minus_shown_o |-> min_tens_o == '0, "minute tens shown with minus")

  // Overtime is only reported by a tick that counted
  `ASSERT_CLK(a_over_counted, clk_i, rst_ni, out_valid_o && overtime_o |-> counted_o, "overtime without count")

  // A counting tick stops the timer only in overtime
  `ASSERT_CLK(a_stop_over, clk_i, rst_ni, out_valid_o && counted_o && !running_o |-> overtime_o, "timer stopped outside overtime")

endmodule

bind countdown_mmss_overtime_timer cmot_checker u_cmot_checker (.*);
